// ----- hw/rtl/pas_pkg.sv -----
package pas_pkg;

    // Default widths of the tick timer and the ramp step counter
    localparam int PAS_TIMER_BITS = 20;
    localparam int PAS_RAMP_BITS  = 12;

    // Fixed field widths
    localparam int DAC_BITS   = 16;
    localparam int TICK_BITS  = 20;
    localparam int STEPS_BITS = 12;
    localparam int CFG_BITS   = 20;
    localparam int CFG_ADDR_BITS = 3;

    // Configuration register indexes
    localparam logic [CFG_ADDR_BITS-1:0] REG_SETTLE   = 3'd0;
    localparam logic [CFG_ADDR_BITS-1:0] REG_MOTOR_ON = 3'd1;
    localparam logic [CFG_ADDR_BITS-1:0] REG_WAIT     = 3'd2;
    localparam logic [CFG_ADDR_BITS-1:0] REG_STEPS    = 3'd3;
    localparam logic [CFG_ADDR_BITS-1:0] REG_MIN      = 3'd4;
    localparam logic [CFG_ADDR_BITS-1:0] REG_MAX      = 3'd5;
    localparam logic [CFG_ADDR_BITS-1:0] REG_SETPOINT = 3'd6;

    // Configuration reset values
    localparam logic [TICK_BITS-1:0]  RST_SETTLE   = 20'd100;
    localparam logic [TICK_BITS-1:0]  RST_MOTOR_ON = 20'd1000;
    localparam logic [TICK_BITS-1:0]  RST_WAIT     = 20'd1000;
    localparam logic [STEPS_BITS-1:0] RST_STEPS    = 12'd100;
    localparam logic [DAC_BITS-1:0]   RST_MIN      = 16'd0;
    localparam logic [DAC_BITS-1:0]   RST_MAX      = 16'd65535;
    localparam logic [DAC_BITS-1:0]   RST_SETPOINT = 16'd32768;

    // Input item kinds
    typedef enum logic [1:0] {
        MODE_TICK  = 2'd0,
        MODE_START = 2'd1,
        MODE_STOP  = 2'd2,
        MODE_NONE  = 2'd3
    } mode_t;

    // Finish causes
    typedef enum logic [1:0] {
        CAUSE_BASE = 2'd0,
        CAUSE_RAMP = 2'd1,
        CAUSE_STOP = 2'd2
    } cause_t;

    // Jump conditions of a microstep
    typedef enum logic [2:0] {
        C_NONE,
        C_DIV_DONE,
        C_STOP,
        C_MOTOR_ZERO,
        C_WAIT_ZERO,
        C_LE_SP,
        C_LT_SP,
        C_RAMP_MORE
    } cond_t;

    // Datapath operations of a microstep
    typedef enum logic [3:0] {
        OP_NOP,
        OP_DIV_START,
        OP_LATCH,
        OP_CYCLE,
        OP_MOTOR_ON,
        OP_MOTOR_OFF,
        OP_LOAD_WAIT,
        OP_RAMP_FIRST,
        OP_RAMP_NEXT,
        OP_RAMP_CLEAR,
        OP_FINISH
    } op_t;

    typedef logic [4:0] upc_t;

    // Program addresses
    localparam upc_t A_IDLE      = 5'd0;
    localparam upc_t A_DIV_INIT  = 5'd1;
    localparam upc_t A_DIV_ITER  = 5'd2;
    localparam upc_t A_DIV_DONE  = 5'd3;
    localparam upc_t A_CYCLE     = 5'd4;
    localparam upc_t A_BASE      = 5'd5;
    localparam upc_t A_MOTOR_GO  = 5'd6;
    localparam upc_t A_MOTOR     = 5'd7;
    localparam upc_t A_MOTOR_OFF = 5'd8;
    localparam upc_t A_FIN_BASE  = 5'd9;
    localparam upc_t A_FIN_STOP  = 5'd10;
    localparam upc_t A_BASE_CHK  = 5'd11;
    localparam upc_t A_WAIT_CHK  = 5'd12;
    localparam upc_t A_WAIT      = 5'd13;
    localparam upc_t A_RAMP_GO   = 5'd14;
    localparam upc_t A_RAMP      = 5'd15;
    localparam upc_t A_RAMP_CHK  = 5'd16;
    localparam upc_t A_FIN_RAMP  = 5'd17;
    localparam upc_t A_RAMP_END  = 5'd18;
    localparam upc_t A_RAMP_NEXT = 5'd19;

    // One control word. Accept steps wait for an item; on a timed step, a tick
    // whose timer expires jumps to t_addr. Other steps jump to t_addr when
    // cond holds, else run op and go to f_addr.
    typedef struct packed {
        logic   accept;
        logic   start_ok;
        logic   timed;
        logic   emit_tick;
        logic   emit_expire;
        cond_t  cond;
        op_t    op;
        cause_t cause;
        upc_t   t_addr;
        upc_t   f_addr;
    } ctrl_t;

    // Microprogram
    function automatic ctrl_t pas_rom(input upc_t a);
        ctrl_t c;
        c = '0;
        c.cond   = C_NONE;
        c.op     = OP_NOP;
        c.cause  = CAUSE_BASE;
        c.t_addr = A_IDLE;
        c.f_addr = A_IDLE;
        case (a)
            A_IDLE:
            begin
                c.accept = 1'b1;
                c.start_ok = 1'b1;
            end
            A_DIV_INIT:
            begin
                c.op = OP_DIV_START;
                c.f_addr = A_DIV_ITER;
            end
            A_DIV_ITER:
            begin
                c.cond = C_DIV_DONE;
                c.t_addr = A_DIV_DONE;
                c.f_addr = A_DIV_ITER;
            end
            A_DIV_DONE:
            begin
                c.op = OP_LATCH;
                c.f_addr = A_CYCLE;
            end
            A_CYCLE:
            begin
                c.cond = C_STOP;
                c.t_addr = A_FIN_STOP;
                c.op = OP_CYCLE;
                c.f_addr = A_BASE;
            end
            A_BASE:
            begin
                c.accept = 1'b1;
                c.timed = 1'b1;
                c.t_addr = A_BASE_CHK;
            end
            A_BASE_CHK:
            begin
                c.cond = C_LE_SP;
                c.t_addr = A_FIN_BASE;
                c.f_addr = A_MOTOR_GO;
            end
            A_MOTOR_GO:
            begin
                c.cond = C_MOTOR_ZERO;
                c.t_addr = A_MOTOR_OFF;
                c.op = OP_MOTOR_ON;
                c.f_addr = A_MOTOR;
            end
            A_MOTOR:
            begin
                c.accept = 1'b1;
                c.timed = 1'b1;
                c.emit_tick = 1'b1;
                c.t_addr = A_MOTOR_OFF;
            end
            A_MOTOR_OFF:
            begin
                c.op = OP_MOTOR_OFF;
                c.f_addr = A_WAIT_CHK;
            end
            A_WAIT_CHK:
            begin
                c.cond = C_WAIT_ZERO;
                c.t_addr = A_RAMP_GO;
                c.op = OP_LOAD_WAIT;
                c.f_addr = A_WAIT;
            end
            A_WAIT:
            begin
                c.accept = 1'b1;
                c.timed = 1'b1;
                c.t_addr = A_RAMP_GO;
            end
            A_RAMP_GO:
            begin
                c.op = OP_RAMP_FIRST;
                c.f_addr = A_RAMP;
            end
            A_RAMP:
            begin
                c.accept = 1'b1;
                c.timed = 1'b1;
                c.emit_expire = 1'b1;
                c.t_addr = A_RAMP_CHK;
            end
            A_RAMP_CHK:
            begin
                c.cond = C_LT_SP;
                c.t_addr = A_FIN_RAMP;
                c.f_addr = A_RAMP_END;
            end
            A_RAMP_END:
            begin
                c.cond = C_RAMP_MORE;
                c.t_addr = A_RAMP_NEXT;
                c.op = OP_RAMP_CLEAR;
                c.f_addr = A_CYCLE;
            end
            A_RAMP_NEXT:
            begin
                c.op = OP_RAMP_NEXT;
                c.f_addr = A_RAMP;
            end
            A_FIN_BASE:
            begin
                c.op = OP_FINISH;
                c.cause = CAUSE_BASE;
                c.f_addr = A_IDLE;
            end
            A_FIN_RAMP:
            begin
                c.op = OP_FINISH;
                c.cause = CAUSE_RAMP;
                c.f_addr = A_IDLE;
            end
            A_FIN_STOP:
            begin
                c.op = OP_FINISH;
                c.cause = CAUSE_STOP;
                c.f_addr = A_IDLE;
            end
            default:
            begin
                c.f_addr = A_IDLE;
            end
        endcase
        return c;
    endfunction

endpackage

// ----- hw/rtl/pas_div.sv -----
module pas_div
    import pas_pkg::*;
#(
    parameter int DIV_BITS = PAS_RAMP_BITS
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    input  logic [DAC_BITS-1:0] dividend,
    input  logic                neg,
    input  logic [DIV_BITS-1:0] divisor,
    output logic                busy,
    output logic [DAC_BITS-1:0] quot
);

    localparam int CNT_BITS = $clog2(DAC_BITS + 1);

    logic [CNT_BITS-1:0] cnt_reg, cnt_next;
    logic [DIV_BITS-1:0] rem_reg, rem_next;
    logic [DAC_BITS-1:0] quo_reg, quo_next;
    logic [DIV_BITS-1:0] dvs_reg, dvs_next;
    logic                neg_reg, neg_next;
    logic [DIV_BITS:0]   trial;

    // One restoring quotient bit per cycle, dividend shifted in from the top
    always_comb
    begin
        cnt_next = cnt_reg;
        rem_next = rem_reg;
        quo_next = quo_reg;
        dvs_next = dvs_reg;
        neg_next = neg_reg;
        trial    = {rem_reg, quo_reg[DAC_BITS-1]};
        if (start)
        begin
            cnt_next = CNT_BITS'(DAC_BITS);
            rem_next = '0;
            quo_next = dividend;
            dvs_next = divisor;
            neg_next = neg;
        end
        else if (cnt_reg != '0)
        begin
            cnt_next = cnt_reg - 1'b1;
            if (trial >= {1'b0, dvs_reg})
            begin
                rem_next = DIV_BITS'(trial - {1'b0, dvs_reg});
                quo_next = {quo_reg[DAC_BITS-2:0], 1'b1};
            end
            else
            begin
                rem_next = DIV_BITS'(trial);
                quo_next = {quo_reg[DAC_BITS-2:0], 1'b0};
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= '0;
        end
        else
        begin
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        dvs_reg <= dvs_next;
        neg_reg <= neg_next;
    end

    // Truncate toward zero: negate the magnitude quotient, wrapped to 16 bits
    assign busy = (cnt_reg != '0);
    assign quot = neg_reg ? DAC_BITS'(-quo_reg) : quo_reg;

endmodule

// ----- hw/rtl/probe_approach_sequencer.sv -----
// Channel  | Direction | tdata                          | tuser        | tlast
// s_axis   | in        | sample[15:0]                   | mode[1:0]    | -
// m_axis   | out       | dac_level, motor_enable,       | sample_valid | finished
//          |           | sample_out, running, cause     |              |
// cfg      | in        | cfg_we / cfg_addr / cfg_wdata, write only         |
//
// A tick that changes no phase runs no microstep; a tick that ends a phase runs
// one to five microsteps of the control program before its result is posted.
// A start item first runs the 16-step serial divider that forms the ramp
// increment. rst_n clears the program counter, the approach state and the
// configuration registers to their defaults. A stalled output holds the next
// item off until the pending transaction is taken.
module probe_approach_sequencer
    import pas_pkg::*;
#(
    parameter int TIMER_BITS = PAS_TIMER_BITS,
    parameter int RAMP_BITS  = PAS_RAMP_BITS
)
(
    input  logic                     clk,
    input  logic                     rst_n,

    input  logic                     cfg_we,
    input  logic [CFG_ADDR_BITS-1:0] cfg_addr,
    input  logic [CFG_BITS-1:0]      cfg_wdata,

    input  logic                     s_tvalid,
    output logic                     s_tready,
    input  logic [15:0]              s_tdata,  // sample[15:0]
    input  logic [1:0]               s_tuser,  // mode[1:0]

    output logic                     m_tvalid,
    input  logic                     m_tready,
    output logic [39:0]              m_tdata,  // dac_level[15:0], motor_enable[16],
                                               // sample_out[32:17], running[33],
                                               // finish_cause[35:34], zero[39:36]
    output logic                     m_tuser,  // sample_valid
    output logic                     m_tlast   // finished
);

    typedef logic [TIMER_BITS-1:0] tim_t;
    typedef logic [RAMP_BITS-1:0]  ridx_t;

    // Configuration registers
    logic [TICK_BITS-1:0]  settle_reg, motor_on_reg, wait_reg;
    logic [STEPS_BITS-1:0] steps_reg;
    logic [DAC_BITS-1:0]   min_reg, max_reg, setpoint_reg;

    // Sequencer and datapath state
    upc_t                upc_reg, upc_next;
    tim_t                timer_reg, timer_next;
    ridx_t               ridx_reg, ridx_next;
    logic [DAC_BITS-1:0] step_reg, step_next;
    logic                stop_reg, stop_next;
    logic [DAC_BITS-1:0] dac_reg, dac_next;
    logic                motor_reg, motor_next;
    logic [DAC_BITS-1:0] smp_reg, smp_next;
    logic                emit_reg, emit_next;
    logic                fin_reg, fin_next;
    cause_t              cause_reg, cause_next;

    // Output register
    logic                m_valid_reg, m_valid_next;
    logic [39:0]         m_data_reg;
    logic                m_user_reg, m_last_reg;

    ctrl_t               cw;
    logic                accept;
    logic                cond_hit;
    logic                push;
    mode_t               mode;
    tim_t                settle_eff, motor_eff, wait_eff;
    ridx_t               steps_eff, steps_raw;
    logic [DAC_BITS:0]   diff;
    logic [DAC_BITS-1:0] diff_mag;
    logic                div_start, div_busy;
    logic [DAC_BITS-1:0] div_quot;

    // Write configuration
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            settle_reg   <= RST_SETTLE;
            motor_on_reg <= RST_MOTOR_ON;
            wait_reg     <= RST_WAIT;
            steps_reg    <= RST_STEPS;
            min_reg      <= RST_MIN;
            max_reg      <= RST_MAX;
            setpoint_reg <= RST_SETPOINT;
        end
        else if (cfg_we)
        begin
            case (cfg_addr)
                REG_SETTLE:   settle_reg   <= cfg_wdata[TICK_BITS-1:0];
                REG_MOTOR_ON: motor_on_reg <= cfg_wdata[TICK_BITS-1:0];
                REG_WAIT:     wait_reg     <= cfg_wdata[TICK_BITS-1:0];
                REG_STEPS:    steps_reg    <= cfg_wdata[STEPS_BITS-1:0];
                REG_MIN:      min_reg      <= cfg_wdata[DAC_BITS-1:0];
                REG_MAX:      max_reg      <= cfg_wdata[DAC_BITS-1:0];
                REG_SETPOINT: setpoint_reg <= cfg_wdata[DAC_BITS-1:0];
                default:      ;
            endcase
        end
    end

    // Effective register values: zero settle and zero steps act as one
    assign motor_eff  = tim_t'(motor_on_reg);
    assign wait_eff   = tim_t'(wait_reg);
    assign settle_eff = (tim_t'(settle_reg) == '0) ? tim_t'(1) : tim_t'(settle_reg);
    assign steps_raw  = ridx_t'(steps_reg);
    assign steps_eff  = (steps_raw == '0) ? ridx_t'(1) : steps_raw;

    // Span of the ramp, split into sign and magnitude for the divider
    assign diff     = {1'b0, max_reg} - {1'b0, min_reg};
    assign diff_mag = diff[DAC_BITS] ? DAC_BITS'(-diff) : diff[DAC_BITS-1:0];

    pas_div #(
        .DIV_BITS (RAMP_BITS)
    ) u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (diff_mag),
        .neg      (diff[DAC_BITS]),
        .divisor  (steps_eff),
        .busy     (div_busy),
        .quot     (div_quot)
    );

    // Fetch the control word of the current step
    assign cw       = pas_rom(upc_reg);
    assign s_tready = cw.accept && (!m_valid_reg || m_tready);
    assign accept   = s_tvalid && s_tready;
    assign mode     = mode_t'(s_tuser);

    // Evaluate the jump condition
    always_comb
    begin
        case (cw.cond)
            C_DIV_DONE:   cond_hit = !div_busy;
            C_STOP:       cond_hit = stop_reg;
            C_MOTOR_ZERO: cond_hit = (motor_eff == '0);
            C_WAIT_ZERO:  cond_hit = (wait_eff == '0);
            C_LE_SP:      cond_hit = (smp_reg <= setpoint_reg);
            C_LT_SP:      cond_hit = (smp_reg < setpoint_reg);
            C_RAMP_MORE:  cond_hit = (ridx_reg < steps_eff);
            default:      cond_hit = 1'b0;
        endcase
    end

    // Dispatch items on accept steps, run the datapath on the others
    always_comb
    begin
        upc_next   = upc_reg;
        timer_next = timer_reg;
        ridx_next  = ridx_reg;
        step_next  = step_reg;
        stop_next  = stop_reg;
        dac_next   = dac_reg;
        motor_next = motor_reg;
        smp_next   = smp_reg;
        emit_next  = emit_reg;
        fin_next   = fin_reg;
        cause_next = cause_reg;
        div_start  = 1'b0;

        if (cw.accept)
        begin
            if (accept)
            begin
                smp_next   = s_tdata;
                emit_next  = 1'b0;
                fin_next   = 1'b0;
                cause_next = CAUSE_BASE;
                case (mode)
                    MODE_START:
                    begin
                        if (cw.start_ok)
                        begin
                            upc_next = A_DIV_INIT;
                        end
                    end
                    MODE_STOP:
                    begin
                        if (upc_reg != A_IDLE)
                        begin
                            stop_next = 1'b1;
                        end
                    end
                    MODE_TICK:
                    begin
                        if (cw.timed)
                        begin
                            emit_next = cw.emit_tick;
                            if (timer_reg > tim_t'(1))
                            begin
                                timer_next = timer_reg - 1'b1;
                            end
                            else
                            begin
                                upc_next  = cw.t_addr;
                                emit_next = cw.emit_tick || cw.emit_expire;
                            end
                        end
                    end
                    default: ;
                endcase
            end
        end
        else if (cond_hit)
        begin
            upc_next = cw.t_addr;
        end
        else
        begin
            upc_next = cw.f_addr;
            case (cw.op)
                OP_DIV_START:
                begin
                    div_start = 1'b1;
                end
                OP_LATCH:
                begin
                    step_next  = div_quot;
                    stop_next  = 1'b0;
                    ridx_next  = '0;
                    motor_next = 1'b0;
                end
                OP_CYCLE:
                begin
                    dac_next   = min_reg;
                    timer_next = settle_eff;
                end
                OP_MOTOR_ON:
                begin
                    motor_next = 1'b1;
                    timer_next = motor_eff;
                end
                OP_MOTOR_OFF:
                begin
                    motor_next = 1'b0;
                end
                OP_LOAD_WAIT:
                begin
                    timer_next = wait_eff;
                end
                OP_RAMP_FIRST:
                begin
                    ridx_next  = ridx_t'(1);
                    dac_next   = dac_reg + step_reg;
                    timer_next = settle_eff;
                end
                OP_RAMP_NEXT:
                begin
                    ridx_next  = ridx_reg + 1'b1;
                    dac_next   = dac_reg + step_reg;
                    timer_next = settle_eff;
                end
                OP_RAMP_CLEAR:
                begin
                    ridx_next = '0;
                end
                OP_FINISH:
                begin
                    motor_next = 1'b0;
                    dac_next   = '0;
                    timer_next = '0;
                    ridx_next  = '0;
                    stop_next  = 1'b0;
                    fin_next   = 1'b1;
                    cause_next = cw.cause;
                end
                default: ;
            endcase
        end
    end

    // Post the result once the program is back at a step that takes items
    assign push = (accept || !cw.accept) && pas_rom(upc_next).accept;

    always_comb
    begin
        m_valid_next = m_valid_reg;
        if (push)
        begin
            m_valid_next = 1'b1;
        end
        else if (m_tready)
        begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            upc_reg     <= A_IDLE;
            timer_reg   <= '0;
            ridx_reg    <= '0;
            step_reg    <= '0;
            stop_reg    <= 1'b0;
            dac_reg     <= '0;
            motor_reg   <= 1'b0;
            emit_reg    <= 1'b0;
            fin_reg     <= 1'b0;
            cause_reg   <= CAUSE_BASE;
            m_valid_reg <= 1'b0;
        end
        else
        begin
            upc_reg     <= upc_next;
            timer_reg   <= timer_next;
            ridx_reg    <= ridx_next;
            step_reg    <= step_next;
            stop_reg    <= stop_next;
            dac_reg     <= dac_next;
            motor_reg   <= motor_next;
            emit_reg    <= emit_next;
            fin_reg     <= fin_next;
            cause_reg   <= cause_next;
            m_valid_reg <= m_valid_next;
        end
    end

    // Hold the sample of the item in flight
    always_ff @(posedge clk)
    begin
        smp_reg <= smp_next;
    end

    // Load the output transaction
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            m_data_reg <= {4'b0000,
                           cause_next,
                           (upc_next != A_IDLE),
                           (emit_next ? smp_next : {DAC_BITS{1'b0}}),
                           motor_next,
                           dac_next};
            m_user_reg <= emit_next;
            m_last_reg <= fin_next;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;
    assign m_tuser  = m_user_reg;
    assign m_tlast  = m_last_reg;

endmodule
